// ===== rtl/bss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the binary search table block.
// No dependencies; every other rtl file refers to this package by scoped names.
package bss_pkg;

    localparam int DATA_W          = 32;
    localparam int IDX_W           = 10;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int S_TDATA_W       = 80;
    localparam int M_TDATA_W       = 16;

    localparam logic [IDX_W-1:0] LAST_INDEX_RST = 10'd1023;

    // action codes carried in s_tuser
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] search_key;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
    } result_t;

endpackage

// ===== rtl/bss_table_ram.sv =====
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous table memory, registered read.
// Depends on bss_pkg for the data width.
module bss_table_ram #(
    parameter int DEPTH = bss_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [AW-1:0]                    waddr,
    input  logic signed [bss_pkg::DATA_W-1:0] wdata,
    input  logic                             re,
    input  logic [AW-1:0]                    raddr,
    output logic signed [bss_pkg::DATA_W-1:0] rdata
);

    logic signed [bss_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [bss_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bss_search_ctrl.sv =====
`timescale 1ns / 1ps
// Probe sequencer: decodes write and search items, walks the search window
// over the table memory. Depends on bss_pkg and bss_table_ram.
module bss_search_ctrl #(
    parameter int TABLE_DEPTH = bss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  bss_pkg::in_item_t           in_item,
    input  logic [bss_pkg::IDX_W-1:0]   last_index,
    output logic                        res_valid,
    input  logic                        res_ready,
    output bss_pkg::result_t            res
);

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int PW      = AW + 2;
    localparam int LastMax = TABLE_DEPTH - 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PROBE = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                            state_reg, state_next;
    logic signed [PW-1:0]              low_reg, low_next;
    logic signed [PW-1:0]              high_reg, high_next;
    logic [AW-1:0]                     mid_reg, mid_next;
    logic signed [bss_pkg::DATA_W-1:0] key_reg, key_next;
    bss_pkg::result_t                  res_reg, res_next;

    logic signed [PW-1:0]              mid;
    logic                              ram_we;
    logic                              ram_re;
    logic signed [bss_pkg::DATA_W-1:0] ram_rdata;

    assign mid = low_reg + ((high_reg - low_reg) >>> 1);

    always_comb
    begin
        state_next = state_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.action == bss_pkg::ACT_WRITE)
                    begin
                        // drop writes beyond the table
                        ram_we = (int'(in_item.entry_index) < TABLE_DEPTH);
                    end
                    else
                    begin
                        low_next   = '0;
                        high_next  = (int'(last_index) > LastMax) ? PW'(LastMax)
                                                                  : PW'(last_index);
                        key_next   = in_item.search_key;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (low_reg > high_reg)
                begin
                    res_next   = '{found: 1'b0, position: '0};
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    mid_next   = mid[AW-1:0];
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (ram_rdata == key_reg)
                begin
                    res_next   = '{found: 1'b1, position: bss_pkg::IDX_W'(mid_reg)};
                    state_next = ST_DONE;
                end
                else
                begin
                    if (key_reg > ram_rdata)
                    begin
                        low_next = PW'(mid_reg) + PW'(1);
                    end
                    else
                    begin
                        high_next = PW'(mid_reg) - PW'(1);
                    end
                    state_next = ST_PROBE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        high_reg <= high_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
        res_reg  <= res_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // Writes land only from idle and reads are issued only from the probe state,
    // so a probe never overlaps a write to the same entry.
    bss_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(in_item.entry_index)),
        .wdata (in_item.entry_value),
        .re    (ram_re),
        .raddr (mid_next),
        .rdata (ram_rdata)
    );

endmodule

// ===== rtl/binary_search_sorted_table.sv =====
`timescale 1ns / 1ps
// Binary search over a sorted table of signed 32-bit values, held in one
// synchronous memory. Depends on bss_pkg and bss_search_ctrl.
//
// Usage:
//   Input stream (s_*): s_tuser selects the action. A write beat stores
//   entry_value at entry_index and gives no result; indexes at or beyond
//   TABLE_DEPTH are dropped. A search beat gives exactly one result beat.
//   Output stream (m_*): m_tuser is the found flag, m_tdata the matched
//   position (zero when not found).
//   Configuration: cfg_wen/cfg_wdata write last_index, the top of the
//   search window; values beyond the table saturate to TABLE_DEPTH - 1.
//   Write it only while no search is in flight.
// Timing:
//   A write beat leaves the engine idle; s_tready stays high after it.
//   Each probe of a search is a memory read, then a compare, and a search
//   makes at most P probes, P being clog2(window size + 1). The next beat
//   is accepted once the result has moved into the output register.
//   One item is worked on at a time; the table read port sets the pace.
// Reset and stalls:
//   Reset clears control state and sets last_index to 1023; table contents
//   stay undefined until written. The result sits in an output register, so
//   new items are accepted while m_tready is low; a further search holds in
//   its final state until the output register frees up.
module binary_search_sorted_table #(
    parameter int TABLE_DEPTH = bss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: entry_index[9:0], entry_value[41:10], search_key[73:42], zero fill
    input  logic [bss_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: action[0]
    input  logic [0:0]                      s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // m_tdata: position[9:0], zero fill
    output logic [bss_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: found[0]
    output logic [0:0]                      m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wen,
    input  logic [bss_pkg::IDX_W-1:0]       cfg_wdata
);

    localparam int IW = bss_pkg::IDX_W;
    localparam int DW = bss_pkg::DATA_W;

    bss_pkg::in_item_t  in_item;
    bss_pkg::result_t   res;
    logic               res_valid;
    logic               res_ready;

    logic [IW-1:0]      last_index_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    bss_pkg::result_t   out_reg, out_next;

    // unpack the input beat
    assign in_item.action      = s_tuser[0];
    assign in_item.entry_index = s_tdata[IW-1:0];
    assign in_item.entry_value = s_tdata[IW+DW-1:IW];
    assign in_item.search_key  = s_tdata[IW+2*DW-1:IW+DW];

    // hold last_index between writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_index_reg <= bss_pkg::LAST_INDEX_RST;
        end
        else if (cfg_wen)
        begin
            last_index_reg <= cfg_wdata;
        end
    end

    bss_search_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .last_index (last_index_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_ready)
        begin
            m_tvalid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.found;
    assign m_tdata  = bss_pkg::M_TDATA_W'(out_reg.position);

endmodule

// ===== rtl/bss_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for binary_search_sorted_table, bound to the top level.
// Depends on bss_pkg for port widths.
module bss_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic [0:0]                    s_tuser,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [bss_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // a miss reports position zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] == 1'b0) |-> m_tdata == '0)
        else $error("miss with nonzero position");

    // a search occupies the engine for at least the next cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == bss_pkg::ACT_SEARCH) |=> !s_tready)
        else $error("input accepted right after a search");

    // a table write leaves the engine ready in the cycle after
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == bss_pkg::ACT_WRITE) |=> s_tready)
        else $error("engine busy after a write");

endmodule

bind binary_search_sorted_table bss_checker u_bss_checker (.*);
